// ===== design/ccr_pkg.sv =====
`timescale 1ns / 1ps
package ccr_pkg;
	localparam int COORD_BITS = 16;
	localparam int DW = COORD_BITS + 1;
	localparam int EPS_W = 15;
	localparam int NUM_W = 4 * DW + 4;
	localparam int DEN_W = 2 * DW + 3;
	localparam int Q_W = NUM_W;
	localparam int SQ_W = 72;
	localparam int RT_W = 36;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DEGEN = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] ax;
		logic signed [COORD_BITS-1:0] ay;
		logic signed [COORD_BITS-1:0] bx;
		logic signed [COORD_BITS-1:0] by_coord;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] centre_x;
		logic signed [31:0] centre_y;
		logic [31:0] radius;
		logic [1:0] status;
	} out_item_t;

	// Setup stage output: numerators and divisors, each as sign and magnitude.
	typedef struct packed {
		logic deg;
		logic signed [COORD_BITS-1:0] bx;
		logic signed [COORD_BITS-1:0] by_coord;
		logic [NUM_W-1:0] nxm;
		logic nx_neg;
		logic [DEN_W-1:0] dxm;
		logic dx_neg;
		logic [NUM_W-1:0] nym;
		logic ny_neg;
		logic [DEN_W-1:0] dym;
		logic dy_neg;
	} div_job_t;
endpackage

// ===== design/ccr_if.sv =====
`timescale 1ns / 1ps
interface ccr_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/ccr_setup.sv =====
`timescale 1ns / 1ps
module ccr_setup (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_v,
	input ccr_pkg::in_item_t in_d,
	input logic [ccr_pkg::EPS_W-1:0] eps,
	output logic out_v,
	output ccr_pkg::div_job_t out_d
);
	import ccr_pkg::*;
	localparam int LW = 2 * DW + 2;
	localparam int PW = 3 * DW + 3;

	logic signed [DW-1:0] ax_d, ay_d, cx_d, cy_d;
	logic [DW-1:0] aay, acy;
	logic flat_a, flat_c;

	assign ax_d = DW'(in_d.ax) - DW'(in_d.bx);
	assign ay_d = DW'(in_d.ay) - DW'(in_d.by_coord);
	assign cx_d = DW'(in_d.cx) - DW'(in_d.bx);
	assign cy_d = DW'(in_d.cy) - DW'(in_d.by_coord);
	assign aay = ay_d[DW-1] ? DW'(-ay_d) : ay_d;
	assign acy = cy_d[DW-1] ? DW'(-cy_d) : cy_d;
	assign flat_a = {1'b0, aay} < (DW+1)'(eps);
	assign flat_c = {1'b0, acy} < (DW+1)'(eps);

	// Stage 1: products of the differences.
	logic v_s1, fa_s1, fc_s1;
	logic signed [DW-1:0] ax_s1, ay_s1, cx_s1, cy_s1;
	logic signed [COORD_BITS-1:0] bx_s1, by_s1;
	logic signed [LW-1:0] la_s1, lc_s1, xa_s1, xc_s1, det_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			fa_s1 <= flat_a; fc_s1 <= flat_c;
			ax_s1 <= ax_d; ay_s1 <= ay_d; cx_s1 <= cx_d; cy_s1 <= cy_d;
			bx_s1 <= in_d.bx; by_s1 <= in_d.by_coord;
			la_s1 <= LW'(ax_d * ax_d) + LW'(ay_d * ay_d);
			lc_s1 <= LW'(cx_d * cx_d) + LW'(cy_d * cy_d);
			xa_s1 <= LW'(cx_d * ax_d);
			xc_s1 <= LW'(ax_d * cx_d);
			det_s1 <= LW'(ax_d * cy_d) - LW'(ay_d * cx_d);
		end
	end

	// Stage 2: numerators and divisors per case.
	logic signed [PW-1:0] p1, p2, p3, p4;
	assign p1 = PW'(cy_s1 * la_s1);
	assign p2 = PW'(ay_s1 * lc_s1);
	assign p3 = PW'(ax_s1 * lc_s1);
	assign p4 = PW'(cx_s1 * la_s1);

	logic signed [NUM_W-1:0] nx, ny;
	logic signed [DEN_W-1:0] dx, dy;
	logic deg;
	always_comb begin
		nx = '0; ny = '0; dx = DEN_W'(2); dy = DEN_W'(2); deg = 1'b0;
		priority if (fa_s1 && fc_s1) begin
			deg = 1'b1;
		end else if (fa_s1) begin
			deg = (cy_s1 == '0);
			nx = NUM_W'(ax_s1);
			ny = NUM_W'(lc_s1) - NUM_W'(xa_s1);
			dy = DEN_W'(cy_s1) <<< 1;
		end else if (fc_s1) begin
			deg = (ay_s1 == '0);
			nx = NUM_W'(cx_s1);
			ny = NUM_W'(la_s1) - NUM_W'(xc_s1);
			dy = DEN_W'(ay_s1) <<< 1;
		end else begin
			deg = (ay_s1 == '0) || (cy_s1 == '0) || (det_s1 == '0);
			dx = DEN_W'(det_s1) <<< 1;
			dy = dx;
			nx = NUM_W'(p1) - NUM_W'(p2);
			ny = NUM_W'(p3) - NUM_W'(p4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v <= 1'b0;
		else if (en) out_v <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_d.deg <= deg;
			out_d.bx <= bx_s1;
			out_d.by_coord <= by_s1;
			out_d.nx_neg <= nx[NUM_W-1];
			out_d.nxm <= nx[NUM_W-1] ? NUM_W'(-nx) : nx;
			out_d.dx_neg <= dx[DEN_W-1];
			out_d.dxm <= dx[DEN_W-1] ? DEN_W'(-dx) : dx;
			out_d.ny_neg <= ny[NUM_W-1];
			out_d.nym <= ny[NUM_W-1] ? NUM_W'(-ny) : ny;
			out_d.dy_neg <= dy[DEN_W-1];
			out_d.dym <= dy[DEN_W-1] ? DEN_W'(-dy) : dy;
		end
	end
endmodule

// ===== design/ccr_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, then rounding.
module ccr_div (
	input logic clk,
	input logic en,
	input logic [ccr_pkg::NUM_W-1:0] num,
	input logic [ccr_pkg::DEN_W-1:0] den,
	output logic [ccr_pkg::Q_W:0] quo
);
	import ccr_pkg::*;
	localparam int RW = DEN_W + 1;

	logic [NUM_W-1:0] n_q [NUM_W+1];
	logic [RW-1:0] r_q [NUM_W+1];
	logic [DEN_W-1:0] d_q [NUM_W+1];

	always_comb begin
		n_q[0] = num; r_q[0] = '0; d_q[0] = den;
	end

	for (genvar i = 0; i < NUM_W; i++) begin : g_st
		logic [RW:0] sh;
		logic ge;
		assign sh = {r_q[i], n_q[i][NUM_W-1]};
		assign ge = sh >= (RW+1)'(d_q[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				r_q[i+1] <= ge ? RW'(sh - (RW+1)'(d_q[i])) : RW'(sh);
				n_q[i+1] <= {n_q[i][NUM_W-2:0], ge};
				d_q[i+1] <= d_q[i];
			end
		end
	end

	assign quo = {1'b0, n_q[NUM_W]} +
		(Q_W+1)'(({r_q[NUM_W], 1'b0}) >= (RW+1)'(d_q[NUM_W]));
endmodule

// ===== design/ccr_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined bit-serial square root, rounded to nearest.
module ccr_sqrt (
	input logic clk,
	input logic en,
	input logic [ccr_pkg::SQ_W-1:0] s,
	output logic [ccr_pkg::RT_W:0] root
);
	import ccr_pkg::*;

	// m_q holds s minus the square of the partial root.
	logic [SQ_W-1:0] m_q [RT_W+1];
	logic [RT_W-1:0] r_q [RT_W+1];

	always_comb begin
		m_q[0] = s; r_q[0] = '0;
	end

	for (genvar i = 0; i < RT_W; i++) begin : g_st
		localparam int B = RT_W - 1 - i;
		// Setting bit B grows the square by 2^(B+1) * r + 2^(2B).
		logic [SQ_W:0] inc;
		logic take;
		assign inc = ((SQ_W+1)'(r_q[i]) << (B + 1)) + ((SQ_W+1)'(1) << (2 * B));
		assign take = inc <= (SQ_W+1)'(m_q[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				r_q[i+1] <= take ? (r_q[i] | (RT_W'(1) << B)) : r_q[i];
				m_q[i+1] <= take ? SQ_W'((SQ_W+1)'(m_q[i]) - inc) : m_q[i];
			end
		end
	end

	assign root = {1'b0, r_q[RT_W]} + (RT_W+1)'(m_q[RT_W] > SQ_W'(r_q[RT_W]));
endmodule

// ===== design/circumcircle_centre_radius.sv =====
`timescale 1ns / 1ps
// Pipeline: an input transfer passes through two setup stages, NUM_W divider stages,
// the centre stage, RT_W root stages and the output register before the result is valid.
// Throughput: one transfer per cycle; the whole pipeline moves when the
// output register is empty or being taken, so a stall holds every stage.
// Reset: arst_n clears all valid bits and sets epsilon to 1.
module circumcircle_centre_radius (
	input logic clk,
	input logic arst_n,
	ccr_if.sink in_ch,
	ccr_if.sink cfg_ch,
	ccr_if.source out_ch
);
	import ccr_pkg::*;
	localparam int DL = NUM_W + 1;
	localparam int SL = RT_W + 1;

	logic [EPS_W-1:0] eps_q;
	logic en;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) eps_q <= EPS_W'(1);
		else if (cfg_ch.valid) eps_q <= cfg_ch.data;
	end

	logic jv;
	div_job_t job;
	ccr_setup u_setup (.clk, .arst_n, .en, .in_v(in_ch.valid && en), .in_d(in_ch.data),
		.eps(eps_q), .out_v(jv), .out_d(job));

	logic [Q_W:0] qx, qy;
	ccr_div u_divx (.clk, .en, .num(job.nxm), .den(job.dxm), .quo(qx));
	ccr_div u_divy (.clk, .en, .num(job.nym), .den(job.dym), .quo(qy));

	// Side data travels alongside the divider.
	logic v_d [DL];
	logic dg_d [DL], sx_d [DL], sy_d [DL];
	logic signed [COORD_BITS-1:0] bx_d [DL], by_d [DL];
	always_comb begin
		v_d[0] = jv; dg_d[0] = job.deg;
		sx_d[0] = job.nx_neg ^ job.dx_neg; sy_d[0] = job.ny_neg ^ job.dy_neg;
		bx_d[0] = job.bx; by_d[0] = job.by_coord;
	end
	for (genvar i = 1; i < DL; i++) begin : g_dl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_d[i] <= 1'b0;
			else if (en) v_d[i] <= v_d[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dg_d[i] <= dg_d[i-1]; sx_d[i] <= sx_d[i-1]; sy_d[i] <= sy_d[i-1];
				bx_d[i] <= bx_d[i-1]; by_d[i] <= by_d[i-1];
			end
		end
	end

	localparam int UW = Q_W + 3;
	logic signed [UW-1:0] ux, uy;
	assign ux = UW'(bx_d[DL-1]) + (sx_d[DL-1] ? -UW'(qx) : UW'(qx));
	assign uy = UW'(by_d[DL-1]) + (sy_d[DL-1] ? -UW'(qy) : UW'(qy));

	// Stage: saturate the centre and form the squared distance.
	logic v_c, dg_c, sat_c;
	logic signed [31:0] cx_c, cy_c;
	logic signed [33:0] ex_c, ey_c;
	logic ox, oy;
	assign ox = (ux > UW'(32'sh7FFFFFFF)) || (ux < -UW'(33'sh80000000));
	assign oy = (uy > UW'(32'sh7FFFFFFF)) || (uy < -UW'(33'sh80000000));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_c <= 1'b0;
		else if (en) v_c <= v_d[DL-1];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dg_c <= dg_d[DL-1];
			sat_c <= ox || oy;
			cx_c <= ox ? (ux[UW-1] ? 32'sh80000000 : 32'sh7FFFFFFF) : ux[31:0];
			cy_c <= oy ? (uy[UW-1] ? 32'sh80000000 : 32'sh7FFFFFFF) : uy[31:0];
			ex_c <= 34'(bx_d[DL-1]) - 34'($signed(ux[31:0]));
			ey_c <= 34'(by_d[DL-1]) - 34'($signed(uy[31:0]));
		end
	end

	logic [SQ_W-1:0] sq;
	assign sq = SQ_W'(ex_c * ex_c) + SQ_W'(ey_c * ey_c);
	logic [RT_W:0] rt;
	ccr_sqrt u_sqrt (.clk, .en, .s(sq), .root(rt));

	logic v_r [SL];
	out_item_t it_r [SL];
	always_comb begin
		v_r[0] = v_c;
		it_r[0].centre_x = dg_c ? '0 : cx_c;
		it_r[0].centre_y = dg_c ? '0 : cy_c;
		it_r[0].radius = '0;
		it_r[0].status = dg_c ? ST_DEGEN : (sat_c ? ST_SAT : ST_OK);
	end
	for (genvar i = 1; i < SL; i++) begin : g_rl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_r[i] <= 1'b0;
			else if (en) v_r[i] <= v_r[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) it_r[i] <= it_r[i-1];
		end
	end
	// The root path is RT_W deep; items wait in it_r, lined up at index RT_W.
	out_item_t fin;
	logic big;
	always_comb begin
		fin = it_r[RT_W];
		big = rt[RT_W] || (rt[RT_W-1:32] != '0);
		unique case (fin.status)
			ST_DEGEN: fin.radius = '0;
			ST_SAT: fin.radius = 32'hFFFFFFFF;
			default: begin
				fin.radius = big ? 32'hFFFFFFFF : rt[31:0];
				fin.status = big ? ST_SAT : ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ch.valid <= 1'b0;
		else if (en) out_ch.valid <= v_r[RT_W];
	end
	always_ff @(posedge clk) begin
		if (en) out_ch.data <= fin;
	end
endmodule
